// ===== design/wspm_pkg.sv =====
// Shared widths, reset values and register indexes for the wheel speed period meter.
`default_nettype none

package wspm_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned STAMP_W  = 16;
    localparam int unsigned DEB_W    = 16;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned CONST_W  = 24;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // One quotient bit per divider step
    localparam int unsigned DIV_STEPS = CONST_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DEB_W-1:0]   DEB_RESET   = DEB_W'(50);
    localparam logic [TMO_W-1:0]   TMO_RESET   = TMO_W'(5000);
    localparam logic [CONST_W-1:0] CONST_RESET = CONST_W'(386089);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_ZERO_TIMEOUT = 2'd1,
        CFG_SPEED_CONST  = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== design/wspm_if.sv =====
// Request and result channel interfaces of the wheel speed period meter.
`default_nettype none

interface wspm_in_if import wspm_pkg::*; ();
    logic valid;
    logic ready;
    logic hall_edge;

    modport source (output valid, output hall_edge, input ready);
    modport sink   (input valid, input hall_edge, output ready);
endinterface

interface wspm_out_if import wspm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_q8;
    logic               speed_new;
    logic               moving;

    modport source (output valid, output speed_q8, output speed_new, output moving,
                    input ready);
    modport sink   (input valid, input speed_q8, input speed_new, input moving,
                    output ready);
endinterface

`default_nettype wire

// ===== design/wheel_speed_period_meter_unit.sv =====
// Wheel speed period meter: tick counter, debounce, period timing and shared divider.
// A tick without a new speed goes from S_IDLE to S_OUT; when a period is divided the request
// is taken in S_IDLE, S_DIV runs 24 restoring divider steps and S_OUT loads the result.
// A new request is taken only in S_IDLE, after the single shift-subtract divider and S_OUT;
// the result register lets the next request enter while the last result waits.
// Reset (i_rst_n low, synchronous): counters, timing state and speed clear, registers
// return to their defaults, the result register empties. No clearing pass is needed.
`default_nettype none

module wheel_speed_period_meter_unit import wspm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    wspm_in_if.sink                    i_req,
    wspm_out_if.source                 o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state               r_state;

    // Configuration registers
    logic [DEB_W-1:0]     r_deb;
    logic [TMO_W-1:0]     r_tmo;
    logic [CONST_W-1:0]   r_const;

    // Timing state
    logic [TIME_W-1:0]    r_ms;
    logic [STAMP_W-1:0]   r_last;
    logic [TIME_W-1:0]    r_rev;
    logic                 r_phase;
    logic [SPEED_W-1:0]   r_speed;
    logic                 r_moving;

    // Pending work for the current request
    logic                 r_fresh;
    logic                 r_clr;

    // Divider
    logic [TIME_W-1:0]    r_div;
    logic [TIME_W-1:0]    r_rem;
    logic [CONST_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Result register
    logic                 r_out_valid;
    logic [SPEED_W-1:0]   r_out_speed;
    logic                 r_out_new;
    logic                 r_out_moving;

    logic                 req_fire;
    logic [TIME_W-1:0]    t_now;
    logic [STAMP_W-1:0]   since;
    logic                 edge_ok;
    logic [TIME_W-1:0]    rev_after;
    logic                 timeout;
    logic [TIME_W:0]      trial;
    logic                 trial_ge;
    logic [SPEED_W-1:0]   quo_sat;
    logic [SPEED_W-1:0]   n_speed;
    logic                 out_free;

    assign i_req.ready      = (r_state == S_IDLE);
    assign req_fire         = i_req.valid && i_req.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.speed_q8   = r_out_speed;
    assign o_res.speed_new  = r_out_new;
    assign o_res.moving     = r_out_moving;
    assign out_free         = !r_out_valid || o_res.ready;

    // Edge qualification and timeout test at the new tick time
    always_comb begin
        t_now     = r_ms + TIME_W'(1);
        since     = t_now[STAMP_W-1:0] - r_last;
        edge_ok   = i_req.hall_edge && (since > r_deb);
        rev_after = edge_ok ? t_now : r_rev;
        timeout   = (t_now - rev_after) >= {{(TIME_W-TMO_W){1'b0}}, r_tmo};
    end

    // One restoring divider step; a zero period yields all ones, which saturates
    always_comb begin
        trial    = {r_rem, r_quo[CONST_W-1]};
        trial_ge = trial >= {1'b0, r_div};
    end

    // Saturate quotient and pick the speed for this tick
    always_comb begin
        quo_sat = (|r_quo[CONST_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : r_quo[SPEED_W-1:0];
        if (r_clr) begin
            n_speed = '0;
        end else if (r_fresh) begin
            n_speed = quo_sat;
        end else begin
            n_speed = r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_deb        <= DEB_RESET;
            r_tmo        <= TMO_RESET;
            r_const      <= CONST_RESET;
            r_ms         <= '0;
            r_last       <= '0;
            r_rev        <= '0;
            r_phase      <= 1'b0;
            r_speed      <= '0;
            r_moving     <= 1'b0;
            r_fresh      <= 1'b0;
            r_clr        <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEBOUNCE:     r_deb   <= i_cfg_data[DEB_W-1:0];
                    CFG_ZERO_TIMEOUT: r_tmo   <= i_cfg_data[TMO_W-1:0];
                    CFG_SPEED_CONST:  r_const <= i_cfg_data[CONST_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_ms    <= t_now;
                        r_fresh <= edge_ok && r_phase;
                        r_clr   <= timeout;
                        if (i_req.hall_edge) begin
                            r_moving <= 1'b1;
                        end
                        if (edge_ok) begin
                            r_last  <= t_now[STAMP_W-1:0];
                            r_rev   <= t_now;
                            r_phase <= 1'b1;
                        end
                        if (timeout) begin
                            r_rev    <= '0;
                            r_phase  <= 1'b0;
                            r_moving <= 1'b0;
                        end
                        // Start the period division
                        r_div <= t_now - r_rev;
                        r_rem <= '0;
                        r_quo <= r_const;
                        r_cnt <= '0;
                        r_state <= (edge_ok && r_phase) ? S_DIV : S_OUT;
                    end
                end

                S_DIV: begin
                    // Advance one quotient bit
                    if (trial_ge) begin
                        r_rem <= trial[TIME_W-1:0] - r_div;
                    end else begin
                        r_rem <= trial[TIME_W-1:0];
                    end
                    r_quo <= {r_quo[CONST_W-2:0], trial_ge};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    // Hold until the result register is free
                    if (out_free) begin
                        r_speed      <= n_speed;
                        r_out_valid  <= 1'b1;
                        r_out_speed  <= n_speed;
                        r_out_new    <= r_fresh;
                        r_out_moving <= r_moving;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the wheel speed period meter, with randomized ticks and stalls.
module tb;
    import wspm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LEN      = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 24;
    localparam int PHASE_TICKS   = 58;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q8;
        logic               speed_new;
        logic               moving;
    } speed_rec_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wspm_in_if  req_ch ();
    wspm_out_if res_ch ();

    wheel_speed_period_meter_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // Tachometer state as predicted on the testbench side
    logic [TIME_W-1:0]  tick_now;
    logic [STAMP_W-1:0] last_hit_ms;
    logic [TIME_W-1:0]  period_start;
    logic               started;
    logic [SPEED_W-1:0] speed_now;
    logic               moving_now;
    logic [DEB_W-1:0]   deb_cfg;
    logic [TMO_W-1:0]   tmo_cfg;
    logic [CONST_W-1:0] k_cfg;

    logic       pending_ticks[$];
    speed_rec_t expected_readings[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int mismatch_count;
    int cycle_count;

    // Clock: 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Advance the tachometer by one millisecond tick and return its outputs
    function automatic speed_rec_t advance_tachometer(input logic hall);
        logic [TIME_W-1:0]  t;
        logic [STAMP_W-1:0] since;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  quot;
        speed_rec_t         rec;
        rec.speed_new = 1'b0;
        tick_now = tick_now + 1'b1;
        t = tick_now;
        if (hall) begin
            moving_now = 1'b1;
            since = t[STAMP_W-1:0] - last_hit_ms;
            if (since > deb_cfg) begin
                if (started) begin
                    period = t - period_start;
                    if (period == '0) begin
                        speed_now = '1;
                    end else begin
                        quot = {8'd0, k_cfg} / period;
                        speed_now = (quot > 32'd65535) ? '1 : quot[SPEED_W-1:0];
                    end
                    rec.speed_new = 1'b1;
                end
                period_start = t;
                started      = 1'b1;
                last_hit_ms  = t[STAMP_W-1:0];
            end
        end
        // Timeout runs every tick, also with no period started
        if ((t - period_start) >= {16'd0, tmo_cfg}) begin
            speed_now    = '0;
            started      = 1'b0;
            period_start = '0;
            moving_now   = 1'b0;
        end
        rec.speed_q8 = speed_now;
        rec.moving   = moving_now;
        return rec;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Driver: offer pending ticks, predict each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.hall_edge <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_readings.push_back(advance_tachometer(req_ch.hall_edge));
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid     <= 1'b1;
                    req_ch.hall_edge <= pending_ticks.pop_front();
                end else begin
                    req_ch.valid     <= 1'b0;
                    req_ch.hall_edge <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Monitor: check each accepted result and drive ready, with long hold-offs on request
    always @(posedge i_clk) begin
        speed_rec_t want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = expected_readings.pop_front();
                    if (res_ch.speed_q8 !== want.speed_q8)
                        report_mismatch($sformatf("speed_q8 got %0h want %0h",
                                                  res_ch.speed_q8, want.speed_q8));
                    if (res_ch.speed_new !== want.speed_new)
                        report_mismatch($sformatf("speed_new got %b want %b",
                                                  res_ch.speed_new, want.speed_new));
                    if (res_ch.moving !== want.moving)
                        report_mismatch($sformatf("moving got %b want %b",
                                                  res_ch.moving, want.moving));
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Wait until every request is taken and every result has come, then let the block settle
    task automatic wait_drained;
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || req_ch.valid || expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers back to back, plus the unused index, then drop the enable
    task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [TMO_W-1:0] tmo,
                              input logic [CONST_W-1:0] k);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DEBOUNCE;
        cfg_data <= CFG_DATA_W'(deb);
        deb_cfg  = deb;
        @(posedge i_clk);
        cfg_idx  <= CFG_ZERO_TIMEOUT;
        cfg_data <= CFG_DATA_W'(tmo);
        tmo_cfg  = tmo;
        @(posedge i_clk);
        cfg_idx  <= CFG_SPEED_CONST;
        cfg_data <= k;
        k_cfg    = k;
        @(posedge i_clk);
        cfg_idx  <= CFG_UNUSED;
        cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic queue_pattern(input string bits);
        for (int i = 0; i < bits.len(); i++)
            pending_ticks.push_back(bits[i] == "1");
    endtask

    // Mostly clean pulse trains around the debounce window, some bounce and noise
    task automatic queue_ride(input int n);
        int made;
        int gap;
        int lo;
        int lo_edge;
        int sel;
        made    = 0;
        lo      = (deb_cfg <= 40) ? int'(deb_cfg) : 0;
        lo_edge = (lo > 0) ? lo - 1 : 0;
        while (made < n) begin
            sel = $urandom_range(99);
            if (sel < 65)
                gap = $urandom_range(lo_edge, lo + 10);
            else if (sel < 75)
                gap = $urandom_range(lo, lo + 90);
            else
                gap = -1;
            if (gap >= 0) begin
                repeat (gap) pending_ticks.push_back(1'b0);
                pending_ticks.push_back(1'b1);
                made += gap + 1;
            end else begin
                repeat (4) pending_ticks.push_back(1'($urandom_range(1)));
                made += 4;
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases
    initial begin
        int                 sel;
        logic [DEB_W-1:0]   deb;
        logic [TMO_W-1:0]   tmo;
        logic [CONST_W-1:0] k;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_DEBOUNCE;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.hall_edge = 1'b0;
        res_ch.ready     = 1'b0;
        send_idle_pct    = 25;
        recv_idle_pct    = 50;
        hold_reqs        = 0;
        hold_seen        = 0;
        hold_left        = 0;
        mismatch_count   = 0;
        tick_now         = '0;
        last_hit_ms      = '0;
        period_start     = '0;
        started          = 1'b0;
        speed_now        = '0;
        moving_now       = 1'b0;
        deb_cfg          = DEB_RESET;
        tmo_cfg          = TMO_RESET;
        k_cfg            = CONST_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: an early edge falls inside the debounce window
        queue_pattern("10");
        wait_drained();
        // Widest constant, one-tick periods: quotient saturates
        write_regs(16'd0, 16'hFFFF, 24'hFFFFFF);
        queue_pattern("111011");
        wait_drained();
        // Zero timeout clears every tick
        write_regs(16'd0, 16'd0, 24'd0);
        queue_pattern("110");
        wait_drained();
        // Rejected bounce, zero constant, then timeout
        write_regs(16'd2, 16'd6, 24'd0);
        queue_pattern("110100000");
        wait_drained();
        // Widest debounce rejects all; timeout while idle drops moving at once
        write_regs(16'hFFFF, 16'd1, 24'h5A5A5A);
        queue_pattern("11");

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph / (PHASES / 3))
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sel = $urandom_range(9);
            deb = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(1, 40));
            sel = $urandom_range(9);
            tmo = (sel == 0) ? 16'd1 : (sel == 1) ? 16'hFFFF :
                  (sel == 2) ? 16'd0 : 16'($urandom_range(2, 120));
            sel = $urandom_range(9);
            k   = (sel == 0) ? 24'd0 : (sel == 1) ? 24'hFFFFFF :
                  (sel == 2) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
            write_regs(deb, tmo, k);
            // Hold the result side off so the block backs up into its input
            if (ph == PHASES - 5) hold_reqs++;
            queue_ride(PHASE_TICKS);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
